[src/rvdg_pkg.sv]
// ----------------------------------------------------------------------------
// rvdg_pkg
// Shared types and constants for the retro video dot generator.
// ----------------------------------------------------------------------------
package rvdg_pkg;

    localparam int ROW_W   = 8;
    localparam int COL_W   = 6;
    localparam int BYTE_W  = 8;
    localparam int FIDX_W  = 9;
    localparam int ADDR_W  = 16;
    localparam int MODE_W  = 2;
    localparam int DOTS_W  = 14;
    localparam int CIDX_W  = 3;

    localparam logic [MODE_W-1:0] MODE_LORES = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HIRES = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TEXT  = 2'd2;

    localparam logic [CIDX_W-1:0] REG_GRAPHICS = 3'd0;
    localparam logic [CIDX_W-1:0] REG_HIRES    = 3'd1;
    localparam logic [CIDX_W-1:0] REG_MIXED    = 3'd2;
    localparam logic [CIDX_W-1:0] REG_PAGE     = 3'd3;
    localparam logic [CIDX_W-1:0] REG_FLASH    = 3'd4;

    localparam logic [ADDR_W-1:0] TEXT_BASE0 = 16'h0400;
    localparam logic [ADDR_W-1:0] TEXT_BASE1 = 16'h0800;
    localparam logic [ADDR_W-1:0] HGR_BASE0  = 16'h2000;
    localparam logic [ADDR_W-1:0] HGR_BASE1  = 16'h4000;
    localparam logic [ROW_W-1:0]  MIXED_ROW  = 8'd160;
    localparam logic [COL_W-1:0]  LAST_COL   = 6'd39;
    localparam logic [BYTE_W-1:0] INV_MASK   = 8'h7f;

    typedef struct packed {
        logic graphics_on;
        logic hires_on;
        logic mixed_on;
        logic page_select;
        logic flash_on;
    } cfg_t;

    typedef struct packed {
        logic [ADDR_W-1:0] fetch_address;
        logic [MODE_W-1:0] mode_used;
        logic [DOTS_W-1:0] dots;
        logic              pending_dot;
    } slot_result_t;

endpackage

[src/retro_video_dot_generator.sv]
// ----------------------------------------------------------------------------
// retro_video_dot_generator
// Character slot to address, mode and 14 dots; font store load path.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  in        input      in_valid / in_ready    kind, scan_row, slot_column,
//                                              video_byte, row_last_byte,
//                                              font_index, font_data
//  out       output     out_valid / out_ready  fetch_address, mode_used,
//                                              dots, end_dot
//  cfg       input      cfg_we                 cfg_index, cfg_data
//
//  One request per cycle while in_ready is high; a slot result is valid once
//  the accepting edge has loaded the input register and read the font store
//  and the result register has then loaded it.
//  Font writes give no result.
//  Reset clears the valid flags, the config and the held dot; the font store is not cleared.
//  A stalled result register holds a valid input stage, which holds in_ready low.
// ----------------------------------------------------------------------------
module retro_video_dot_generator
    import rvdg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              kind,
    input  logic [ROW_W-1:0]  scan_row,
    input  logic [COL_W-1:0]  slot_column,
    input  logic [BYTE_W-1:0] video_byte,
    input  logic [BYTE_W-1:0] row_last_byte,
    input  logic [FIDX_W-1:0] font_index,
    input  logic [BYTE_W-1:0] font_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ADDR_W-1:0] fetch_address,
    output logic [MODE_W-1:0] mode_used,
    output logic [DOTS_W-1:0] dots,
    output logic              end_dot,
    input  logic              cfg_we,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic              cfg_data
);

    cfg_t              cfg_reg;
    logic              s1_valid_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic [BYTE_W-1:0] s1_last_reg;
    logic              pending_reg;
    logic              out_valid_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [DOTS_W-1:0] dots_reg;
    logic              end_dot_reg;

    logic              accept;
    logic              advance;
    logic [FIDX_W-1:0] font_rd_addr;
    logic [BYTE_W-1:0] font_byte;
    slot_result_t      result;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    assign font_rd_addr = {video_byte[5:0] ^ 6'h20, scan_row[2:0]};

    rvdg_font_mem u_font_mem
    (
        .clk     (clk),
        .wr_en   (accept && kind),
        .wr_addr (font_index),
        .wr_data (font_data),
        .rd_en   (accept),
        .rd_addr (font_rd_addr),
        .rd_data (font_byte)
    );

    rvdg_slot_logic u_slot_logic
    (
        .cfg           (cfg_reg),
        .scan_row      (s1_row_reg),
        .slot_column   (s1_col_reg),
        .video_byte    (s1_byte_reg),
        .row_last_byte (s1_last_reg),
        .font_byte     (font_byte),
        .pending_dot   (pending_reg),
        .result        (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GRAPHICS: cfg_reg.graphics_on <= cfg_data;
                REG_HIRES:    cfg_reg.hires_on    <= cfg_data;
                REG_MIXED:    cfg_reg.mixed_on    <= cfg_data;
                REG_PAGE:     cfg_reg.page_select <= cfg_data;
                REG_FLASH:    cfg_reg.flash_on    <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pending_reg   <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= accept && !kind;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
                if (s1_valid_reg)
                begin
                    pending_reg <= result.pending_dot;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_row_reg  <= scan_row;
            s1_col_reg  <= slot_column;
            s1_byte_reg <= video_byte;
            s1_last_reg <= row_last_byte;
        end
        if (advance && s1_valid_reg)
        begin
            addr_reg    <= result.fetch_address;
            mode_reg    <= result.mode_used;
            dots_reg    <= result.dots;
            end_dot_reg <= (s1_col_reg == LAST_COL) && result.pending_dot;
        end
    end

    assign out_valid     = out_valid_reg;
    assign fetch_address = addr_reg;
    assign mode_used     = mode_reg;
    assign dots          = dots_reg;
    assign end_dot       = end_dot_reg;

endmodule

[src/rvdg_font_mem.sv]
// ----------------------------------------------------------------------------
// rvdg_font_mem
// Font store: 512 x 8 memory with separate write and read ports and registered read data.
// ----------------------------------------------------------------------------
module rvdg_font_mem
    import rvdg_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [FIDX_W-1:0] wr_addr,
    input  logic [BYTE_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [FIDX_W-1:0] rd_addr,
    output logic [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] mem [2**FIDX_W];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/rvdg_slot_logic.sv]
// ----------------------------------------------------------------------------
// rvdg_slot_logic
// Per-slot address, mode select and dot pattern for one character slot.
// ----------------------------------------------------------------------------
module rvdg_slot_logic
    import rvdg_pkg::*;
(
    input  cfg_t              cfg,
    input  logic [ROW_W-1:0]  scan_row,
    input  logic [COL_W-1:0]  slot_column,
    input  logic [BYTE_W-1:0] video_byte,
    input  logic [BYTE_W-1:0] row_last_byte,
    input  logic [BYTE_W-1:0] font_byte,
    input  logic              pending_dot,
    output slot_result_t      result
);

    logic              lower_area;
    logic              is_lores;
    logic              is_text;
    logic              col_zero;
    logic [1:0]        block_sel;
    logic [ADDR_W-1:0] block_off;
    logic [ADDR_W-1:0] text_off;
    logic [ADDR_W-1:0] hgr_off;
    logic [ADDR_W-1:0] text_base;
    logic [ADDR_W-1:0] hgr_base;
    logic [3:0]        nib;
    logic [1:0]        phase;
    logic              inverse;
    logic [BYTE_W-1:0] seg;
    logic              pink;
    logic              lead;
    logic [DOTS_W-1:0] lores_dots;
    logic [DOTS_W-1:0] byte_dots;

    assign lower_area = (scan_row >= MIXED_ROW) && cfg.mixed_on;
    assign is_text    = !cfg.graphics_on || lower_area;
    assign is_lores   = !is_text && !cfg.hires_on;
    assign col_zero   = (slot_column == '0);

    assign block_sel = scan_row[7:6];
    assign block_off = ADDR_W'({block_sel, 5'b0}) + ADDR_W'({block_sel, 3'b0});
    assign text_off  = ADDR_W'({scan_row[5:3], 7'b0}) + block_off;
    assign hgr_off   = ADDR_W'({scan_row[2:0], 10'b0}) + text_off;
    assign text_base = cfg.page_select ? TEXT_BASE1 : TEXT_BASE0;
    assign hgr_base  = cfg.page_select ? HGR_BASE1 : HGR_BASE0;

    assign nib   = scan_row[2] ? video_byte[7:4] : video_byte[3:0];
    assign phase = {slot_column[0], 1'b0};

    assign inverse = (video_byte[7:6] == 2'b00) ||
                     ((video_byte[7:6] == 2'b01) && cfg.flash_on);
    assign seg     = is_text ? (font_byte ^ (inverse ? INV_MASK : '0)) : video_byte;
    assign pink    = video_byte[7] && row_last_byte[6];
    assign lead    = col_zero ? pink : pending_dot;

    always_comb
    begin
        lores_dots    = '0;
        lores_dots[0] = col_zero ? 1'b0 : pending_dot;
        for (int j = 1; j < DOTS_W; j++)
        begin
            lores_dots[j] = nib[2'(phase + 2'(j - 1))];
        end
    end

    always_comb
    begin
        byte_dots = '0;
        if (seg[7])
        begin
            for (int j = 0; j < DOTS_W; j++)
            begin
                byte_dots[j] = seg[j >> 1];
            end
        end
        else
        begin
            byte_dots[0] = lead;
            for (int j = 1; j < DOTS_W; j++)
            begin
                byte_dots[j] = seg[(j - 1) >> 1];
            end
        end
    end

    always_comb
    begin
        if (is_lores)
        begin
            result.fetch_address = text_base + text_off + ADDR_W'(slot_column);
            result.mode_used     = MODE_LORES;
            result.dots          = lores_dots;
            result.pending_dot   = nib[2'(phase + 2'd1)];
        end
        else if (is_text)
        begin
            result.fetch_address = text_base + text_off + ADDR_W'(slot_column);
            result.mode_used     = MODE_TEXT;
            result.dots          = byte_dots;
            result.pending_dot   = seg[6];
        end
        else
        begin
            result.fetch_address = hgr_base + hgr_off + ADDR_W'(slot_column);
            result.mode_used     = MODE_HIRES;
            result.dots          = byte_dots;
            result.pending_dot   = seg[6];
        end
    end

endmodule
